@@ rtl/core/uad_pkg.sv @@
// Shared types, micro-op codes and jump conditions for the ASCII digit converter.
// No dependencies; used by uad_ucode_rom, uad_datapath and the top level.
package uad_pkg;

    // Datapath operations, one per control word
    typedef logic [2:0] t_op;
    localparam t_op OP_NOP  = 3'd0;
    localparam t_op OP_LOAD = 3'd1;   // capture request on handshake
    localparam t_op OP_MUL  = 3'd2;   // quotient by ten via reciprocal multiply
    localparam t_op OP_DEC  = 3'd3;   // store decimal digit, value <= quotient
    localparam t_op OP_HEX  = 3'd4;   // store low nibble, value <= value >> 4
    localparam t_op OP_EMIT = 3'd5;   // present digit characters, top first

    // Jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond C_NEVER    = 3'd0;
    localparam t_cond C_ALWAYS   = 3'd1;
    localparam t_cond C_IN_FIRE  = 3'd2;
    localparam t_cond C_IS_HEX   = 3'd3;
    localparam t_cond C_Q_NZ     = 3'd4;
    localparam t_cond C_HEX_MORE = 3'd5;
    localparam t_cond C_OUT_LAST = 3'd6;

    localparam int STEP_W     = 3;
    localparam int MAX_DIGITS = 10;
    localparam int DIG_IDX_W  = 4;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
        logic  hold;      // stay on this step when the condition is false
    } t_uword;

    typedef struct packed {
        logic is_hex;
        logic q_nz;
        logic hex_more;
        logic emit_last;
    } t_status;

    localparam logic [1:0]  MODE_HEX_LO = 2'd1;
    localparam logic [1:0]  MODE_HEX_UP = 2'd2;

    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;  // ceil(2^35 / 10)
    localparam int          RECIP_SHIFT = 35;

    localparam logic [6:0]  DIGIT_BASE   = 7'd48;
    localparam logic [6:0]  LOWER_OFFSET = 7'd87;
    localparam logic [6:0]  UPPER_OFFSET = 7'd55;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] off;
        if (d < 4'd10) begin
            off = DIGIT_BASE;
        end else if (upper) begin
            off = UPPER_OFFSET;
        end else begin
            off = LOWER_OFFSET;
        end
        return {3'b000, d} + off;
    endfunction

endpackage

@@ rtl/core/uad_ucode_rom.sv @@
// Control store of the digit converter: one control word per step.
// Depends on uad_pkg.
module uad_ucode_rom (
    input  uad_pkg::t_step  i_step,
    output uad_pkg::t_uword o_word
);
    import uad_pkg::*;

    always_comb begin
        unique case (i_step)
            3'd0:    o_word = '{op: OP_LOAD, cond: C_IN_FIRE,  target: 3'd1, hold: 1'b1};
            3'd1:    o_word = '{op: OP_NOP,  cond: C_IS_HEX,   target: 3'd5, hold: 1'b0};
            3'd2:    o_word = '{op: OP_MUL,  cond: C_NEVER,    target: 3'd0, hold: 1'b0};
            3'd3:    o_word = '{op: OP_DEC,  cond: C_Q_NZ,     target: 3'd2, hold: 1'b0};
            3'd4:    o_word = '{op: OP_EMIT, cond: C_OUT_LAST, target: 3'd0, hold: 1'b1};
            3'd5:    o_word = '{op: OP_HEX,  cond: C_HEX_MORE, target: 3'd5, hold: 1'b0};
            3'd6:    o_word = '{op: OP_EMIT, cond: C_OUT_LAST, target: 3'd0, hold: 1'b1};
            default: o_word = '{op: OP_NOP,  cond: C_ALWAYS,   target: 3'd0, hold: 1'b0};
        endcase
    end

endmodule

@@ rtl/core/uad_datapath.sv @@
// Datapath of the digit converter: value register, divide-by-ten, digit store, char encode.
// Depends on uad_pkg.
module uad_datapath (
    input  logic            i_clk,
    input  uad_pkg::t_op    i_op,
    input  logic            i_in_fire,
    input  logic            i_out_fire,
    input  logic [31:0]     i_value,
    input  logic [1:0]      i_radix_mode,
    output uad_pkg::t_status o_status,
    output logic [6:0]      o_char
);
    import uad_pkg::*;

    logic [31:0]          r_val;
    logic [28:0]          r_q;
    logic [3:0]           r_dig [MAX_DIGITS];
    logic [DIG_IDX_W-1:0] r_cnt;
    logic [DIG_IDX_W-1:0] r_idx;
    logic                 r_hex;
    logic                 r_upper;

    logic [63:0] w_prod;
    logic [31:0] w_q10;
    logic [31:0] w_rem;

    assign w_prod = 64'(r_val) * 64'(RECIP10);
    assign w_q10  = {r_q, 3'b000} + {2'b00, r_q, 1'b0};
    assign w_rem  = r_val - w_q10;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                if (i_in_fire) begin
                    r_val   <= i_value;
                    r_hex   <= (i_radix_mode == MODE_HEX_LO) || (i_radix_mode == MODE_HEX_UP);
                    r_upper <= (i_radix_mode == MODE_HEX_UP);
                    r_cnt   <= '0;
                end
            end
            OP_MUL: begin
                r_q <= w_prod[RECIP_SHIFT +: 29];
            end
            OP_DEC: begin
                r_dig[r_cnt] <= w_rem[3:0];
                r_val        <= {3'b000, r_q};
                r_idx        <= r_cnt;
                r_cnt        <= r_cnt + 1'b1;
            end
            OP_HEX: begin
                r_dig[r_cnt] <= r_val[3:0];
                r_val        <= {4'b0000, r_val[31:4]};
                r_idx        <= r_cnt;
                r_cnt        <= r_cnt + 1'b1;
            end
            OP_EMIT: begin
                if (i_out_fire && (r_idx != '0)) begin
                    r_idx <= r_idx - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_status.is_hex    = r_hex;
    assign o_status.q_nz      = (r_q != '0);
    assign o_status.hex_more  = (r_val[31:4] != '0);
    assign o_status.emit_last = (r_idx == '0);

    assign o_char = digit_char(r_dig[r_idx], r_upper);

endmodule

@@ rtl/core/unsigned_to_ascii_digits_core.sv @@
// Unsigned binary to ASCII digit converter, top level: step counter and stream ports.
// Depends on uad_pkg, uad_ucode_rom and uad_datapath.
//
// Each request carries a 32-bit unsigned value and a format (0 decimal, 1 lowercase
// hex, 2 uppercase hex, 3 decimal). The block answers with the ASCII digits of the
// value, most significant first, no leading zeros, one character per transfer, with
// tlast on the final one; zero gives the single character '0'. One request is worked
// at a time. A request is first accepted and then branched on its format. A decimal
// request then does, per digit, the reciprocal multiply by 1/10 and stores the
// remainder, taken against the registered quotient, as the next digit; a hex request
// stores one nibble per cycle. The digits then go out as one character per cycle
// while the sink is ready. Control comes from an eight-word control store; each word
// names a datapath op, a jump condition, a jump target and whether to hold on a false
// condition.
module unsigned_to_ascii_digits_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] value, [33:32] radix_mode, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] ascii_char, [7] zero
    output logic        m_axis_tlast    // last_char
);
    import uad_pkg::*;

    t_step   r_step;
    t_step   n_step;
    t_uword  w_word;
    t_status w_status;
    logic    w_in_fire;
    logic    w_out_fire;
    logic    w_take;
    logic [6:0] w_char;

    uad_ucode_rom u_rom (
        .i_step (r_step),
        .o_word (w_word)
    );

    uad_datapath u_dp (
        .i_clk        (i_clk),
        .i_op         (w_word.op),
        .i_in_fire    (w_in_fire),
        .i_out_fire   (w_out_fire),
        .i_value      (s_axis_tdata[31:0]),
        .i_radix_mode (s_axis_tdata[33:32]),
        .o_status     (w_status),
        .o_char       (w_char)
    );

    // Handshakes are driven straight from the current control word
    assign s_axis_tready = (w_word.op == OP_LOAD);
    assign m_axis_tvalid = (w_word.op == OP_EMIT);
    assign m_axis_tdata  = {1'b0, w_char};
    assign m_axis_tlast  = w_status.emit_last;

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_fire = m_axis_tvalid && m_axis_tready;

    // Jump condition select
    always_comb begin
        unique case (w_word.cond)
            C_NEVER:    w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_IN_FIRE:  w_take = w_in_fire;
            C_IS_HEX:   w_take = w_status.is_hex;
            C_Q_NZ:     w_take = w_status.q_nz;
            C_HEX_MORE: w_take = w_status.hex_more;
            C_OUT_LAST: w_take = w_out_fire && w_status.emit_last;
            default:    w_take = 1'b0;
        endcase
    end

    always_comb begin
        priority if (w_take) begin
            n_step = w_word.target;
        end else if (w_word.hold) begin
            n_step = r_step;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
